// ===== rtl/core/xs128_pkg.sv =====
// shared constants, types and helper functions of the xorshift128 generator
package xs128_pkg;

   localparam int unsigned WordWidth = 32;

   // reset words of the generator
   localparam logic [WordWidth-1:0] RESET_X = 32'd123456789;
   localparam logic [WordWidth-1:0] RESET_Y = 32'd362436069;
   localparam logic [WordWidth-1:0] RESET_Z = 32'd521288629;
   localparam logic [WordWidth-1:0] RESET_W = 32'd88675123;

   // seed expansion constants
   localparam logic [WordWidth-1:0] SEED_MUL = 32'd1812433253;
   localparam logic [WordWidth-1:0] SEED_K_X = 32'd123464980;
   localparam logic [WordWidth-1:0] SEED_K_Y = 32'd3447902351;
   localparam logic [WordWidth-1:0] SEED_K_Z = 32'd2859490775;
   localparam logic [WordWidth-1:0] SEED_K_W = 32'd47621719;

   // number of expansion passes before falling back to the reset words
   localparam int unsigned SeedTries = 16;
   localparam int unsigned PassWidth = $clog2(SeedTries);

   // shift amounts
   localparam int unsigned DrawShiftA = 11;
   localparam int unsigned DrawShiftB = 8;
   localparam int unsigned DrawShiftC = 19;
   localparam int unsigned MixShiftA  = 13;
   localparam int unsigned MixShiftB  = 17;

   // word index inside one expansion pass
   localparam logic [1:0] ROUND_X = 2'd0;
   localparam logic [1:0] ROUND_Y = 2'd1;
   localparam logic [1:0] ROUND_Z = 2'd2;
   localparam logic [1:0] ROUND_W = 2'd3;

   // operation codes
   typedef enum logic [1:0] {
      OP_DRAW = 2'd0,
      OP_SEED = 2'd1,
      OP_LOAD = 2'd2
   } op_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       apply;       // draw, load or no-op from the request
      logic       seed_start;  // latch the request seed
      logic       mul;         // multiply-add step of a mixing round
      logic       mix;         // shift-xor step, writes one word
      logic       restore;     // fall back to the reset words
      logic       finish;      // load the response register
      logic [1:0] round;       // word written by the mix step
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic words_zero;        // all four words zero after the last round
   } status_type;

   // constant xored into the word of a given round
   function automatic logic [WordWidth-1:0] seed_key(input logic [1:0] round);
      logic [WordWidth-1:0] key;
      case (round)
         ROUND_X: key = SEED_K_X;
         ROUND_Y: key = SEED_K_Y;
         ROUND_Z: key = SEED_K_Z;
         default: key = SEED_K_W;
      endcase
      return key;
   endfunction

   // shift-xor half of a mixing round
   function automatic logic [WordWidth-1:0] mix_shift(input logic [WordWidth-1:0] p);
      logic [WordWidth-1:0] a;
      a = p ^ (p << MixShiftA);
      return a ^ (a >> MixShiftB);
   endfunction

endpackage

// ===== rtl/core/xs128_req_if.sv =====
// request channel of the xorshift128 generator
interface xs128_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] seed;
   logic [31:0] load_x;
   logic [31:0] load_y;
   logic [31:0] load_z;
   logic [31:0] load_w;

   modport source (output valid, op, seed, load_x, load_y, load_z, load_w, input ready);
   modport sink (input valid, op, seed, load_x, load_y, load_z, load_w, output ready);
endinterface

// ===== rtl/core/xs128_rsp_if.sv =====
// response channel of the xorshift128 generator
interface xs128_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] sample;
   logic [31:0] word_x;
   logic [31:0] word_y;
   logic [31:0] word_z;
   logic [31:0] word_w;

   modport source (output valid, sample, word_x, word_y, word_z, word_w, input ready);
   modport sink (input valid, sample, word_x, word_y, word_z, word_w, output ready);
endinterface

// ===== rtl/core/xs128_ctrl.sv =====
// controller: request handshake, seed expansion sequencing, response valid
module xs128_ctrl
   import xs128_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_MIX
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           round_ff, round_in;
   logic [PassWidth-1:0] pass_ff, pass_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;

   // a new request may enter in idle once the response register is free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      cmd.round = round_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_SEED) begin
                  cmd.seed_start = 1'b1;
                  round_in       = ROUND_X;
                  pass_in        = '0;
                  state_in       = ST_MUL;
               end else begin
                  cmd.apply  = 1'b1;
                  cmd.finish = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix = 1'b1;
            if (round_ff == ROUND_W) begin
               if (!status.words_zero) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else if (pass_ff == PassWidth'(SeedTries - 1)) begin
                  cmd.restore = 1'b1;
                  cmd.finish  = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  pass_in  = pass_ff + 1'b1;
                  round_in = ROUND_X;
                  state_in = ST_MUL;
               end
            end else begin
               round_in = round_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= ROUND_X;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/xs128_dpath.sv =====
// datapath: generator words, seed mixing unit and response register
module xs128_dpath
   import xs128_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [1:0]           req_op,
   input  logic [WordWidth-1:0] req_seed,
   input  logic [WordWidth-1:0] req_load_x,
   input  logic [WordWidth-1:0] req_load_y,
   input  logic [WordWidth-1:0] req_load_z,
   input  logic [WordWidth-1:0] req_load_w,
   output logic [WordWidth-1:0] rsp_x,
   output logic [WordWidth-1:0] rsp_y,
   output logic [WordWidth-1:0] rsp_z,
   output logic [WordWidth-1:0] rsp_w
);

   logic [WordWidth-1:0] gen_x_ff, gen_y_ff, gen_z_ff, gen_w_ff;
   logic [WordWidth-1:0] gen_x_in, gen_y_in, gen_z_in, gen_w_in;
   logic [WordWidth-1:0] seed_ff, seed_in;
   logic [WordWidth-1:0] prod_ff, prod_in;
   logic [WordWidth-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_w_ff;
   logic [WordWidth-1:0] mixed;
   logic [WordWidth-1:0] mix_word;
   logic [WordWidth-1:0] draw_t;
   logic [WordWidth-1:0] draw_w;

   // one xorshift128 step
   assign draw_t = gen_x_ff ^ (gen_x_ff << DrawShiftA);
   assign draw_w = gen_w_ff ^ (gen_w_ff >> DrawShiftC) ^ draw_t ^ (draw_t >> DrawShiftB);

   // mixing round: multiply-add registered, shift-xor in the next cycle
   assign prod_in  = seed_ff * SEED_MUL + 32'd1;
   assign mixed    = mix_shift(prod_ff);
   assign mix_word = seed_key(cmd.round) ^ mixed;

   always_comb begin
      if (cmd.seed_start) begin
         seed_in = req_seed;
      end else if (cmd.mix) begin
         seed_in = mixed;
      end else begin
         seed_in = seed_ff;
      end
   end

   // all-zero check on the word set finished by the last round
   assign status.words_zero = ((gen_x_ff | gen_y_ff | gen_z_ff | mix_word) == '0);

   // next generator words
   always_comb begin
      gen_x_in = gen_x_ff;
      gen_y_in = gen_y_ff;
      gen_z_in = gen_z_ff;
      gen_w_in = gen_w_ff;
      if (cmd.restore) begin
         gen_x_in = RESET_X;
         gen_y_in = RESET_Y;
         gen_z_in = RESET_Z;
         gen_w_in = RESET_W;
      end else if (cmd.mix) begin
         case (cmd.round)
            ROUND_X: gen_x_in = mix_word;
            ROUND_Y: gen_y_in = mix_word;
            ROUND_Z: gen_z_in = mix_word;
            default: gen_w_in = mix_word;
         endcase
      end else if (cmd.apply) begin
         case (req_op)
            OP_DRAW: begin
               gen_x_in = gen_y_ff;
               gen_y_in = gen_z_ff;
               gen_z_in = gen_w_ff;
               gen_w_in = draw_w;
            end
            OP_LOAD: begin
               gen_x_in = req_load_x;
               gen_y_in = req_load_y;
               gen_z_in = req_load_z;
               gen_w_in = req_load_w;
            end
            default: begin
               gen_x_in = gen_x_ff;
            end
         endcase
      end
   end

   // generator words
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_x_ff <= RESET_X;
         gen_y_ff <= RESET_Y;
         gen_z_ff <= RESET_Z;
         gen_w_ff <= RESET_W;
      end else begin
         gen_x_ff <= gen_x_in;
         gen_y_ff <= gen_y_in;
         gen_z_ff <= gen_z_in;
         gen_w_ff <= gen_w_in;
      end
   end

   // mixing registers
   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_x_ff <= gen_x_in;
         rsp_y_ff <= gen_y_in;
         rsp_z_ff <= gen_z_in;
         rsp_w_ff <= gen_w_in;
      end
   end

   assign rsp_x = rsp_x_ff;
   assign rsp_y = rsp_y_ff;
   assign rsp_z = rsp_z_ff;
   assign rsp_w = rsp_w_ff;

endmodule

// ===== rtl/core/xorshift128_uniform_generator.sv =====
// top level of the xorshift128 uniform generator
//
//   channel   direction  accepted when        payload
//   req_ch    in         valid && ready       op, seed, load_x..load_w
//   rsp_ch    out        valid && ready       sample, word_x..word_w
//
// Draw, load and unused op codes finish on acceptance; a response is presented the
// cycle after the request is taken, and back-to-back draws run one per cycle while
// each response is taken. A seed request runs up to 16 expansion passes (multiply,
// then shift-xor, for each of four words) on the shared 32x32 multiplier.
// Synchronous reset loads the four fixed generator words and empties the response.
// A stalled response holds its register; a new request waits during a seed
// expansion or while that register is full and not being taken.
module xorshift128_uniform_generator
   import xs128_pkg::*;
(
   input logic          clock,
   input logic          reset,
   xs128_req_if.sink    req_ch,
   xs128_rsp_if.source  rsp_ch
);

   cmd_type              cmd;
   status_type           status;
   logic [WordWidth-1:0] rsp_x, rsp_y, rsp_z, rsp_w;

   // sequencing
   xs128_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // generator state and arithmetic
   xs128_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_ch.op),
      .req_seed   (req_ch.seed),
      .req_load_x (req_ch.load_x),
      .req_load_y (req_ch.load_y),
      .req_load_z (req_ch.load_z),
      .req_load_w (req_ch.load_w),
      .rsp_x      (rsp_x),
      .rsp_y      (rsp_y),
      .rsp_z      (rsp_z),
      .rsp_w      (rsp_w)
   );

   // response payload
   assign rsp_ch.word_x = rsp_x;
   assign rsp_ch.word_y = rsp_y;
   assign rsp_ch.word_z = rsp_z;
   assign rsp_ch.word_w = rsp_w;
   assign rsp_ch.sample = {rsp_w, rsp_x};

endmodule

// ===== rtl/core/xs128_checker.sv =====
// port-level checks of the xorshift128 generator and their binding
module xs128_checker
   import xs128_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_op,
   input logic [31:0] req_load_x,
   input logic [31:0] req_load_w,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_sample,
   input logic [31:0] rsp_word_x,
   input logic [31:0] rsp_word_w
);

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no request taken while a stalled response occupies the output register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request accepted over a pending response");

   // draw and load answer in the next cycle, load reports the written words
   a_load_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_LOAD) |=>
         rsp_valid && (rsp_word_x == $past(req_load_x)) && (rsp_word_w == $past(req_load_w)))
      else $error("load response missing or wrong");

   a_draw_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_DRAW) |=> rsp_valid)
      else $error("draw response missing");

   // sample is made of the reported words
   a_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample == {rsp_word_w, rsp_word_x})
      else $error("sample does not match state words");

endmodule

bind xorshift128_uniform_generator xs128_checker u_xs128_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_op     (req_ch.op),
   .req_load_x (req_ch.load_x),
   .req_load_w (req_ch.load_w),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_sample (rsp_ch.sample),
   .rsp_word_x (rsp_ch.word_x),
   .rsp_word_w (rsp_ch.word_w)
);

// ===== tb/xs128_checker.sv =====
// watches both channels of the xorshift128 generator, predicts each response and compares it
module xs128_scoreboard
   import xs128_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   xs128_req_if        req_mon,
   xs128_rsp_if        rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
   } gen_words_type;

   typedef struct packed {
      logic [63:0]   sample;
      gen_words_type words;
   } gen_result_type;

   gen_words_type  gen_state;
   gen_result_type predicted_results[$];

   // one multiply-add and shift-xor round of the seed expansion
   function automatic logic [31:0] seed_round(input logic [31:0] s);
      logic [31:0] t;
      t = s * SEED_MUL + 32'd1;
      t = t ^ (t << MixShiftA);
      t = t ^ (t >> MixShiftB);
      return t;
   endfunction

   // generator words after one request
   function automatic gen_words_type next_words(input gen_words_type cur, input logic [1:0] op,
                                                input logic [31:0] seed,
                                                input gen_words_type load);
      gen_words_type nxt;
      logic [31:0]   t;
      logic [31:0]   s;
      bit            found;
      nxt = cur;
      case (op)
         OP_DRAW: begin
            t     = cur.x ^ (cur.x << DrawShiftA);
            nxt.x = cur.y;
            nxt.y = cur.z;
            nxt.z = cur.w;
            nxt.w = cur.w ^ (cur.w >> DrawShiftC) ^ t ^ (t >> DrawShiftB);
         end
         OP_SEED: begin
            s     = seed;
            found = 1'b0;
            for (int pass = 0; pass < SeedTries && !found; pass++) begin
               s     = seed_round(s);
               nxt.x = SEED_K_X ^ s;
               s     = seed_round(s);
               nxt.y = SEED_K_Y ^ s;
               s     = seed_round(s);
               nxt.z = SEED_K_Z ^ s;
               s     = seed_round(s);
               nxt.w = SEED_K_W ^ s;
               found = (nxt.x | nxt.y | nxt.z | nxt.w) != 32'd0;
            end
            // every pass came out all zero: fall back to the reset words
            if (!found) begin
               nxt = '{RESET_X, RESET_Y, RESET_Z, RESET_W};
            end
         end
         OP_LOAD: begin
            nxt = load;
         end
         default: begin
            // unused op code leaves the words alone
            nxt = cur;
         end
      endcase
      return nxt;
   endfunction

   // compare responses against the oldest prediction, then predict new requests
   always @(posedge clock) begin
      gen_result_type expected_r;
      gen_words_type  after;
      int unsigned    errs;
      errs = 0;
      if (reset) begin
         gen_state = '{RESET_X, RESET_Y, RESET_Z, RESET_W};
         predicted_results.delete();
         mismatch_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_results.size() == 0) begin
               $error("response with no request outstanding: sample %h", rsp_mon.sample);
               errs++;
            end else begin
               expected_r = predicted_results.pop_front();
               if (rsp_mon.sample !== expected_r.sample) begin
                  $error("sample: expected %h, got %h", expected_r.sample, rsp_mon.sample);
                  errs++;
               end
               if (rsp_mon.word_x !== expected_r.words.x) begin
                  $error("word_x: expected %h, got %h", expected_r.words.x, rsp_mon.word_x);
                  errs++;
               end
               if (rsp_mon.word_y !== expected_r.words.y) begin
                  $error("word_y: expected %h, got %h", expected_r.words.y, rsp_mon.word_y);
                  errs++;
               end
               if (rsp_mon.word_z !== expected_r.words.z) begin
                  $error("word_z: expected %h, got %h", expected_r.words.z, rsp_mon.word_z);
                  errs++;
               end
               if (rsp_mon.word_w !== expected_r.words.w) begin
                  $error("word_w: expected %h, got %h", expected_r.words.w, rsp_mon.word_w);
                  errs++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            after = next_words(gen_state, req_mon.op, req_mon.seed,
                               '{req_mon.load_x, req_mon.load_y, req_mon.load_z, req_mon.load_w});
            gen_state = after;
            predicted_results.push_back('{{after.w, after.x}, after});
         end
         mismatch_count <= mismatch_count + errs;
      end
      pending_count <= predicted_results.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// top of the xorshift128 generator testbench: clock, reset, stimulus and verdict
module tb_top
   import xs128_pkg::*;
();

   localparam logic [1:0]  OpUnused    = 2'd3;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned RandomItems = 500;
   localparam int unsigned LongHold    = 200;
   localparam int unsigned FlushCycles = 20;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   bit          sender_steady;
   bit          receiver_steady;
   bit          hold_requested;

   xs128_req_if req_ch ();
   xs128_rsp_if rsp_ch ();

   xorshift128_uniform_generator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   xs128_scoreboard u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // offer one request after a random gap and hold it until taken
   task automatic send_request(input logic [1:0] op, input logic [31:0] seed,
                               input logic [31:0] lx, input logic [31:0] ly,
                               input logic [31:0] lz, input logic [31:0] lw);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.op     <= op;
      req_ch.seed   <= seed;
      req_ch.load_x <= lx;
      req_ch.load_y <= ly;
      req_ch.load_z <= lz;
      req_ch.load_w <= lw;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // request with a random op, mostly draws; all payload bits random
   task automatic send_random_item();
      int unsigned pick;
      logic [1:0]  op;
      pick = $urandom_range(0, 99);
      if (pick < 75)      op = OP_DRAW;
      else if (pick < 85) op = OP_LOAD;
      else if (pick < 95) op = OP_SEED;
      else                op = OpUnused;
      send_request(op, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   // random stretch, with occasional runs where one or both sides never idle
   task automatic run_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
         end
         send_random_item();
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_requested) begin
            rsp_ch.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            hold_requested = 1'b0;
         end
         stall = receiver_steady ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // stimulus and verdict
   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.op       <= OP_DRAW;
      req_ch.seed     <= '0;
      req_ch.load_x   <= '0;
      req_ch.load_y   <= '0;
      req_ch.load_z   <= '0;
      req_ch.load_w   <= '0;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      hold_requested  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // draws from the reset words
      send_request(OP_DRAW, '0, '0, '0, '0, '0);
      send_request(OP_DRAW, '1, '1, '1, '1, '1);
      send_request(OP_DRAW, '0, '0, '0, '0, '0);
      // seed extremes
      send_request(OP_SEED, 32'h0000_0000, '0, '0, '0, '0);
      send_request(OP_SEED, 32'hffff_ffff, '0, '0, '0, '0);
      send_request(OP_SEED, 32'h0000_0001, '0, '0, '0, '0);
      send_request(OP_SEED, 32'h8000_0000, '0, '0, '0, '0);
      send_request(OP_DRAW, '0, '0, '0, '0, '0);
      // all-zero load sticks at zero on draws
      send_request(OP_LOAD, '0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(OP_DRAW, '0, '0, '0, '0, '0);
      send_request(OP_DRAW, '0, '0, '0, '0, '0);
      // all-ones and alternating loads
      send_request(OP_LOAD, '0, '1, '1, '1, '1);
      send_request(OP_DRAW, '0, '0, '0, '0, '0);
      send_request(OP_LOAD, '0, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
      send_request(OP_DRAW, '0, '0, '0, '0, '0);
      send_request(OP_LOAD, '0, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0000);
      send_request(OP_DRAW, '0, '0, '0, '0, '0);
      // unused op code reports the words unchanged
      send_request(OpUnused, '1, '1, '1, '1, '1);
      send_request(OP_SEED, 32'h1234_5678, '0, '0, '0, '0);
      send_request(OpUnused, '0, '0, '0, '0, '0);
      send_request(OP_DRAW, '0, '0, '0, '0, '0);
      drain_results();

      run_random(RandomItems * 2 / 5);

      // long response hold-off while requests keep coming back to back
      hold_requested = 1'b1;
      sender_steady  = 1'b1;
      for (int unsigned i = 0; i < 60; i++) begin
         send_random_item();
      end
      sender_steady = 1'b0;
      drain_results();

      run_random(RandomItems - RandomItems * 2 / 5 - 60);

      drain_results();
      repeat (FlushCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/xs128_pkg.sv
rtl/core/xs128_req_if.sv
rtl/core/xs128_rsp_if.sv
rtl/core/xs128_ctrl.sv
rtl/core/xs128_dpath.sv
rtl/core/xorshift128_uniform_generator.sv
rtl/core/xs128_checker.sv
tb/xs128_checker.sv
tb/tb_top.sv
